/* src/ray_sphere_hit_test_top_defines.svh */
// Assertion macros for the ray/sphere hit test.
`ifndef RAY_SPHERE_HIT_TEST_TOP_DEFINES_SVH
`define RAY_SPHERE_HIT_TEST_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define RSHT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsht assertion failed");

// Implication with a delay given by dly, disabled in reset.
`define RSHT_ASSERT_DELAY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("rsht delayed assertion failed");

`endif

/* src/rsht_pkg.sv */
// Shared widths and pipeline control type for the ray/sphere hit test.
package rsht_pkg;

  localparam int IN_W     = 32;
  localparam int LEN_W    = 31;
  localparam int A_W      = 64;
  localparam int HB_W     = 66;
  localparam int MAG_W    = 64;
  localparam int HALF_W   = 32;
  localparam int PROD_W   = 128;
  localparam int DISC_W   = 130;
  localparam int RAD_W    = 126;
  localparam int ROOT_W   = 63;
  localparam int REM_W    = 66;
  localparam int SQ_STEPS = 63;
  localparam int NUM_W    = 67;
  localparam int Q_W      = 32;

  typedef struct packed {
    logic                     valid;
    logic                     rej;
    logic [LEN_W-1:0]         tmax;
    logic [A_W-1:0]           a;
    logic signed [HB_W-1:0]   hb;
  } ray_ctl_t;

endpackage

/* src/ray_sphere_hit_test_top.sv */
// Ray/sphere hit test: fully pipelined quadratic, square root and division.
//
// One request is taken every cycle (busy is always low). Each result appears
// on out_valid/out_hit/out_hit_distance from the output register and is shown
// for one cycle only: the receiver cannot stall. The pipeline consists of six
// arithmetic stages, a 63-stage bit-per-stage square root, one numerator
// stage, a 32-stage restoring divider per root and an output stage.
// sphere_radius is written through cfg_we/cfg_wdata while no request is in
// flight (a user rule, not enforced by the block); it resets to 1.0.
`include "ray_sphere_hit_test_top_defines.svh"

module ray_sphere_hit_test_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [rsht_pkg::IN_W-1:0]   in_origin_x,
  input  logic signed [rsht_pkg::IN_W-1:0]   in_origin_y,
  input  logic signed [rsht_pkg::IN_W-1:0]   in_origin_z,
  input  logic signed [rsht_pkg::IN_W-1:0]   in_dir_x,
  input  logic signed [rsht_pkg::IN_W-1:0]   in_dir_y,
  input  logic signed [rsht_pkg::IN_W-1:0]   in_dir_z,
  input  logic [rsht_pkg::LEN_W-1:0]         in_max_distance,
  input  logic                               cfg_we,
  input  logic [rsht_pkg::LEN_W-1:0]         cfg_wdata,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [rsht_pkg::LEN_W-1:0]         out_hit_distance
);

  localparam int NW  = 96 + FRAC_BITS;
  localparam int LAT = 6 + rsht_pkg::SQ_STEPS + 1 + rsht_pkg::Q_W + 1;

  logic [rsht_pkg::LEN_W-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= rsht_pkg::LEN_W'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // stage 1: products
  rsht_pkg::ray_ctl_t          s1_ctl_r;
  logic [63:0]                 s1_dd_r [0:2];
  logic signed [63:0]          s1_do_r [0:2];
  logic [63:0]                 s1_oo_r [0:2];
  logic [61:0]                 s1_rr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r.valid <= 1'b0;
    end else begin
      s1_ctl_r.valid <= start;
      s1_ctl_r.rej   <= 1'b0;
      s1_ctl_r.tmax  <= in_max_distance;
      s1_ctl_r.a     <= '0;
      s1_ctl_r.hb    <= '0;
      s1_dd_r[0] <= in_dir_x * in_dir_x;
      s1_dd_r[1] <= in_dir_y * in_dir_y;
      s1_dd_r[2] <= in_dir_z * in_dir_z;
      s1_do_r[0] <= in_dir_x * in_origin_x;
      s1_do_r[1] <= in_dir_y * in_origin_y;
      s1_do_r[2] <= in_dir_z * in_origin_z;
      s1_oo_r[0] <= in_origin_x * in_origin_x;
      s1_oo_r[1] <= in_origin_y * in_origin_y;
      s1_oo_r[2] <= in_origin_z * in_origin_z;
      s1_rr_r    <= radius_r * radius_r;
    end
  end

  // stage 2: dot products
  rsht_pkg::ray_ctl_t                 s2_ctl_r;
  logic signed [rsht_pkg::HB_W-1:0]   s2_c_r;
  logic [63:0]                        oo_sum;

  assign oo_sum = s1_oo_r[0] + s1_oo_r[1] + s1_oo_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r.valid <= 1'b0;
    end else begin
      s2_ctl_r.valid <= s1_ctl_r.valid;
      s2_ctl_r.tmax  <= s1_ctl_r.tmax;
      s2_ctl_r.a     <= s1_dd_r[0] + s1_dd_r[1] + s1_dd_r[2];
      s2_ctl_r.rej   <= (s1_dd_r[0] + s1_dd_r[1] + s1_dd_r[2]) == '0;
      s2_ctl_r.hb    <= rsht_pkg::HB_W'(s1_do_r[0]) + rsht_pkg::HB_W'(s1_do_r[1])
                        + rsht_pkg::HB_W'(s1_do_r[2]);
      s2_c_r         <= $signed({2'b00, oo_sum}) - $signed({4'b0000, s1_rr_r});
    end
  end

  // stage 3: magnitudes
  rsht_pkg::ray_ctl_t          s3_ctl_r;
  logic [rsht_pkg::MAG_W-1:0]  s3_hbm_r;
  logic [rsht_pkg::MAG_W-1:0]  s3_cm_r;
  logic                        s3_cneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r.valid <= 1'b0;
    end else begin
      s3_ctl_r  <= s2_ctl_r;
      s3_hbm_r  <= s2_ctl_r.hb[rsht_pkg::HB_W-1] ? rsht_pkg::MAG_W'(-s2_ctl_r.hb)
                                                  : rsht_pkg::MAG_W'(s2_ctl_r.hb);
      s3_cm_r   <= s2_c_r[rsht_pkg::HB_W-1] ? rsht_pkg::MAG_W'(-s2_c_r)
                                             : rsht_pkg::MAG_W'(s2_c_r);
      s3_cneg_r <= s2_c_r[rsht_pkg::HB_W-1];
    end
  end

  // stage 4: 32x32 partial products
  localparam int H = rsht_pkg::HALF_W;
  rsht_pkg::ray_ctl_t s4_ctl_r;
  logic [63:0]        s4_bhh_r, s4_bhl_r, s4_bll_r;
  logic [63:0]        s4_chh_r, s4_chl_r, s4_clh_r, s4_cll_r;
  logic               s4_cneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r.valid <= 1'b0;
    end else begin
      s4_ctl_r  <= s3_ctl_r;
      s4_cneg_r <= s3_cneg_r;
      s4_bhh_r  <= s3_hbm_r[2*H-1:H] * s3_hbm_r[2*H-1:H];
      s4_bhl_r  <= s3_hbm_r[2*H-1:H] * s3_hbm_r[H-1:0];
      s4_bll_r  <= s3_hbm_r[H-1:0] * s3_hbm_r[H-1:0];
      s4_chh_r  <= s3_ctl_r.a[2*H-1:H] * s3_cm_r[2*H-1:H];
      s4_chl_r  <= s3_ctl_r.a[2*H-1:H] * s3_cm_r[H-1:0];
      s4_clh_r  <= s3_ctl_r.a[H-1:0] * s3_cm_r[2*H-1:H];
      s4_cll_r  <= s3_ctl_r.a[H-1:0] * s3_cm_r[H-1:0];
    end
  end

  // stage 5: full products
  rsht_pkg::ray_ctl_t          s5_ctl_r;
  logic [rsht_pkg::PROD_W-1:0] s5_hb2_r, s5_ac_r;
  logic                        s5_cneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_ctl_r.valid <= 1'b0;
    end else begin
      s5_ctl_r  <= s4_ctl_r;
      s5_cneg_r <= s4_cneg_r;
      s5_hb2_r  <= {s4_bhh_r, s4_bll_r} + (rsht_pkg::PROD_W'(s4_bhl_r) << (H + 1));
      s5_ac_r   <= {s4_chh_r, s4_cll_r}
                   + ((rsht_pkg::PROD_W'(s4_chl_r) + rsht_pkg::PROD_W'(s4_clh_r)) << H);
    end
  end

  // stage 6: discriminant, feeds the square root
  logic signed [rsht_pkg::DISC_W-1:0] disc;
  rsht_pkg::ray_ctl_t                 disc_ctl;

  assign disc = s5_cneg_r ? $signed({2'b00, s5_hb2_r}) + $signed({2'b00, s5_ac_r})
                          : $signed({2'b00, s5_hb2_r}) - $signed({2'b00, s5_ac_r});

  always_comb begin
    disc_ctl     = s5_ctl_r;
    disc_ctl.rej = s5_ctl_r.rej | disc[rsht_pkg::DISC_W-1];
  end

  rsht_pkg::ray_ctl_t          sq_ctl_r  [0:rsht_pkg::SQ_STEPS];
  logic [rsht_pkg::RAD_W-1:0]  sq_rad_r  [0:rsht_pkg::SQ_STEPS];
  logic [rsht_pkg::REM_W-1:0]  sq_rem_r  [0:rsht_pkg::SQ_STEPS];
  logic [rsht_pkg::ROOT_W-1:0] sq_root_r [0:rsht_pkg::SQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_ctl_r[0].valid <= 1'b0;
    end else begin
      sq_ctl_r[0]     <= disc_ctl;
      sq_rad_r[0]     <= disc[rsht_pkg::RAD_W-1:0];
      sq_rem_r[0]     <= '0;
      sq_root_r[0]    <= '0;
    end
  end

  for (genvar i = 0; i < rsht_pkg::SQ_STEPS; i++) begin : g_sqrt
    logic [rsht_pkg::REM_W+1:0] rem_t;
    logic [rsht_pkg::REM_W+1:0] trial;
    logic                       ge;

    assign rem_t = {sq_rem_r[i], sq_rad_r[i][rsht_pkg::RAD_W-1 -: 2]};
    assign trial = {3'b000, sq_root_r[i], 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_ctl_r[i+1].valid <= 1'b0;
      end else begin
        sq_ctl_r[i+1]  <= sq_ctl_r[i];
        sq_rem_r[i+1]  <= ge ? rsht_pkg::REM_W'(rem_t - trial) : rsht_pkg::REM_W'(rem_t);
        sq_root_r[i+1] <= {sq_root_r[i][rsht_pkg::ROOT_W-2:0], ge};
        sq_rad_r[i+1]  <= {sq_rad_r[i][rsht_pkg::RAD_W-3:0], 2'b00};
      end
    end
  end

  // numerators -hb -/+ s, feed both dividers
  logic signed [rsht_pkg::NUM_W-1:0] hbx, sx, n0, n1;
  logic                              pos0, pos1;

  assign hbx  = rsht_pkg::NUM_W'(sq_ctl_r[rsht_pkg::SQ_STEPS].hb);
  assign sx   = $signed({4'b0000, sq_root_r[rsht_pkg::SQ_STEPS]});
  assign n0   = -hbx - sx;
  assign n1   = -hbx + sx;
  assign pos0 = !n0[rsht_pkg::NUM_W-1] && (n0 != '0);
  assign pos1 = !n1[rsht_pkg::NUM_W-1] && (n1 != '0);

  rsht_pkg::ray_ctl_t       dv_ctl_r  [0:rsht_pkg::Q_W];
  logic [NW-1:0]            dv_rem0_r [0:rsht_pkg::Q_W];
  logic [NW-1:0]            dv_rem1_r [0:rsht_pkg::Q_W];
  logic [rsht_pkg::Q_W-1:0] dv_q0_r   [0:rsht_pkg::Q_W];
  logic [rsht_pkg::Q_W-1:0] dv_q1_r   [0:rsht_pkg::Q_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_ctl_r[0].valid <= 1'b0;
    end else begin
      dv_ctl_r[0]  <= sq_ctl_r[rsht_pkg::SQ_STEPS];
      dv_rem0_r[0] <= pos0 ? (NW'(n0[rsht_pkg::NUM_W-2:0]) << FRAC_BITS) : '0;
      dv_rem1_r[0] <= pos1 ? (NW'(n1[rsht_pkg::NUM_W-2:0]) << FRAC_BITS) : '0;
      dv_q0_r[0]   <= '0;
      dv_q1_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < rsht_pkg::Q_W; j++) begin : g_div
    localparam int P = rsht_pkg::Q_W - 1 - j;
    logic [NW-1:0] den;
    logic          ge0, ge1;

    assign den = NW'(dv_ctl_r[j].a) << P;
    assign ge0 = dv_rem0_r[j] >= den;
    assign ge1 = dv_rem1_r[j] >= den;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_ctl_r[j+1].valid <= 1'b0;
      end else begin
        dv_ctl_r[j+1]  <= dv_ctl_r[j];
        dv_rem0_r[j+1] <= ge0 ? dv_rem0_r[j] - den : dv_rem0_r[j];
        dv_rem1_r[j+1] <= ge1 ? dv_rem1_r[j] - den : dv_rem1_r[j];
        dv_q0_r[j+1]   <= {dv_q0_r[j][rsht_pkg::Q_W-2:0], ge0};
        dv_q1_r[j+1]   <= {dv_q1_r[j][rsht_pkg::Q_W-2:0], ge1};
      end
    end
  end

  // root selection and range checks
  rsht_pkg::ray_ctl_t       fc;
  logic [rsht_pkg::Q_W-1:0] q0, q1;
  logic                     le0_0, le0_1, gt0, gt1, reject;
  logic                     out_valid_r, out_hit_r;
  logic [rsht_pkg::LEN_W-1:0] out_dist_r;

  assign fc     = dv_ctl_r[rsht_pkg::Q_W];
  assign q0     = dv_q0_r[rsht_pkg::Q_W];
  assign q1     = dv_q1_r[rsht_pkg::Q_W];
  assign le0_0  = q0 == '0;
  assign le0_1  = q1 == '0;
  assign gt0    = q0[rsht_pkg::Q_W-1] || (q0[rsht_pkg::LEN_W-1:0] > fc.tmax);
  assign gt1    = q1[rsht_pkg::Q_W-1] || (q1[rsht_pkg::LEN_W-1:0] > fc.tmax);
  assign reject = fc.rej || gt0 || le0_1 || (le0_0 && gt1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
    end else begin
      out_valid_r <= fc.valid;
      out_hit_r   <= fc.valid && !reject;
      out_dist_r  <= reject ? '0
                   : (le0_0 ? q1[rsht_pkg::LEN_W-1:0] : q0[rsht_pkg::LEN_W-1:0]);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_distance = out_dist_r;

  `RSHT_ASSERT_IMPL(a_hit_has_strobe, out_hit_r, out_valid_r)
  `RSHT_ASSERT_IMPL(a_miss_zero_dist, out_valid_r && !out_hit_r, out_dist_r == '0)
  `RSHT_ASSERT_DELAY(a_fixed_latency, start, LAT, out_valid_r)
  `RSHT_ASSERT_IMPL(a_zero_dir_miss, fc.valid && fc.a == '0, reject)

endmodule
